// File: hw/rtl/i2cte_pkg.sv
package i2cte_pkg;

  // flags raised by the start and stop watchers
  typedef struct packed {
    logic start;
    logic stop;
  } flags_t;

  // one result item
  typedef struct packed {
    logic       sda_drive_enable;
    logic       sda_drive_value;
    logic       start_seen;
    logic [7:0] received_byte;
    logic       received_valid;
  } result_t;

endpackage

// File: hw/rtl/i2cte_in_if.sv
interface i2cte_in_if;
  logic       valid;
  logic       ready;
  logic       restart;
  logic       scl_level;
  logic       sda_level;
  logic [7:0] reply_byte;

  modport source (
    output valid, restart, scl_level, sda_level, reply_byte,
    input  ready
  );
  modport sink (
    input  valid, restart, scl_level, sda_level, reply_byte,
    output ready
  );
endinterface

// File: hw/rtl/i2cte_out_if.sv
interface i2cte_out_if;
  logic       valid;
  logic       ready;
  logic       sda_drive_enable;
  logic       sda_drive_value;
  logic       start_seen;
  logic [7:0] received_byte;
  logic       received_valid;

  modport source (
    output valid, sda_drive_enable, sda_drive_value, start_seen, received_byte,
           received_valid,
    input  ready
  );
  modport sink (
    input  valid, sda_drive_enable, sda_drive_value, start_seen, received_byte,
           received_valid,
    output ready
  );
endinterface

// File: hw/rtl/i2cte_cond_watch.sv
module i2cte_cond_watch (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  logic             restart_i,
  input  logic             scl_i,
  input  logic             sda_i,
  output i2cte_pkg::flags_t flags_q_o,
  output i2cte_pkg::flags_t flags_d_o
);

  typedef enum logic [1:0] {
    SwWaitHigh = 2'd0,
    SwSawLow   = 2'd1,
    SwSawHigh  = 2'd2
  } sw_state_e;

  sw_state_e         start_watch_q, start_watch_d;
  logic              stop_watch_q, stop_watch_d;
  i2cte_pkg::flags_t flags_q, flags_d;

  always_comb begin
    start_watch_d = start_watch_q;
    stop_watch_d  = stop_watch_q;
    flags_d       = '0;
    if (restart_i) begin
      start_watch_d = SwWaitHigh;
      stop_watch_d  = 1'b0;
    end else begin
      unique case (start_watch_q)
        SwWaitHigh: begin
          if (scl_i) start_watch_d = sda_i ? SwSawHigh : SwSawLow;
        end
        SwSawLow: begin
          if (!scl_i) start_watch_d = SwWaitHigh;
          else if (sda_i) start_watch_d = SwSawHigh;
        end
        SwSawHigh: begin
          if (!scl_i) begin
            start_watch_d = SwWaitHigh;
          end else if (!sda_i) begin
            flags_d.start = 1'b1;
            start_watch_d = SwWaitHigh;
          end
        end
        default: start_watch_d = SwWaitHigh;
      endcase

      // stop: sda rises while scl stays high
      if (!stop_watch_q) begin
        if (scl_i && !sda_i) stop_watch_d = 1'b1;
      end else if (scl_i && sda_i) begin
        flags_d.stop = 1'b1;
        stop_watch_d = 1'b0;
      end else if (!scl_i) begin
        stop_watch_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_watch_q <= SwWaitHigh;
      stop_watch_q  <= 1'b0;
      flags_q       <= '0;
    end else if (advance_i) begin
      start_watch_q <= start_watch_d;
      stop_watch_q  <= stop_watch_d;
      flags_q       <= flags_d;
    end
  end

  assign flags_q_o = flags_q;
  assign flags_d_o = flags_d;

endmodule

// File: hw/rtl/i2cte_byte_engine.sv
module i2cte_byte_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  logic               restart_i,
  input  logic               scl_i,
  input  logic               sda_i,
  input  logic [7:0]         reply_byte_i,
  input  i2cte_pkg::flags_t  flags_q_i,
  input  i2cte_pkg::flags_t  flags_d_i,
  output i2cte_pkg::result_t result_o
);

  typedef enum logic [1:0] {
    PhIdle        = 2'd0,
    PhWaitLowInit = 2'd1,
    PhWaitHigh    = 2'd2,
    PhWaitLow     = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KindAddress = 2'd0,
    KindWrite   = 2'd1,
    KindRead    = 2'd2
  } kind_e;

  localparam logic [3:0] AckSlot     = 4'd8;
  localparam logic [3:0] LastDataBit = 4'd7;

  phase_e     phase_q, phase_d;
  kind_e      kind_q, kind_d;
  logic [7:0] shift_q, shift_d;
  logic [3:0] bit_pos_q, bit_pos_d;
  logic       ctrl_ack_q, ctrl_ack_d;
  logic [7:0] reply_q, reply_d;
  logic       drive_q, drive_d;
  logic       released_q, released_d;
  logic [7:0] held_q, held_d;
  logic       rx_valid;
  logic [2:0] bit_idx;

  // msb first: bit 0 of the count selects bit 7 of the byte
  assign bit_idx = 3'd7 - bit_pos_q[2:0];

  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    shift_d    = shift_q;
    bit_pos_d  = bit_pos_q;
    ctrl_ack_d = ctrl_ack_q;
    reply_d    = reply_q;
    drive_d    = drive_q;
    released_d = released_q;
    held_d     = held_q;
    rx_valid   = 1'b0;
    if (restart_i) begin
      phase_d    = PhIdle;
      kind_d     = KindAddress;
      shift_d    = '0;
      bit_pos_d  = '0;
      ctrl_ack_d = 1'b1;
      reply_d    = '0;
      drive_d    = 1'b1;
      released_d = 1'b1;
      held_d     = '0;
    end else if (flags_q_i.stop) begin
      phase_d    = PhIdle;
      released_d = 1'b1;
    end else begin
      unique case (phase_q)
        PhIdle: begin
          released_d = 1'b1;
          if (flags_q_i.start) begin
            reply_d    = reply_byte_i;
            phase_d    = PhWaitLowInit;
            kind_d     = KindAddress;
            ctrl_ack_d = 1'b1;
          end
        end
        PhWaitLowInit: begin
          if (!scl_i) begin
            phase_d   = PhWaitHigh;
            bit_pos_d = '0;
            shift_d   = '0;
          end
        end
        PhWaitHigh: begin
          if (scl_i) begin
            phase_d = PhWaitLow;
            if (kind_q != KindRead && bit_pos_q < AckSlot) shift_d[bit_idx] = sda_i;
            if (kind_q == KindRead && bit_pos_q == AckSlot) ctrl_ack_d = sda_i;
            if (bit_pos_q == AckSlot) begin
              bit_pos_d = '0;
              held_d    = shift_q;
              rx_valid  = 1'b1;
            end else begin
              bit_pos_d = bit_pos_q + 4'd1;
            end
          end
        end
        PhWaitLow: begin
          if (flags_q_i.start) begin
            phase_d    = PhWaitLowInit;
            kind_d     = KindAddress;
            ctrl_ack_d = 1'b1;
          end else if (!scl_i) begin
            phase_d = PhWaitHigh;
            if (bit_pos_q == AckSlot) begin
              if (kind_q == KindRead) begin
                released_d = 1'b1;
              end else begin
                released_d = 1'b0;
                drive_d    = 1'b0;
              end
              // address lsb picks the direction
              if (kind_q == KindAddress) kind_d = shift_q[0] ? KindRead : KindWrite;
            end else if (kind_q == KindRead) begin
              released_d = ctrl_ack_q;
              if (bit_pos_q <= LastDataBit) drive_d = reply_q[bit_idx];
            end else begin
              released_d = 1'b1;
            end
          end
        end
        default: phase_d = PhIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhIdle;
      kind_q     <= KindAddress;
      shift_q    <= '0;
      bit_pos_q  <= '0;
      ctrl_ack_q <= 1'b1;
      reply_q    <= '0;
      drive_q    <= 1'b1;
      released_q <= 1'b1;
      held_q     <= '0;
    end else if (advance_i) begin
      phase_q    <= phase_d;
      kind_q     <= kind_d;
      shift_q    <= shift_d;
      bit_pos_q  <= bit_pos_d;
      ctrl_ack_q <= ctrl_ack_d;
      reply_q    <= reply_d;
      drive_q    <= drive_d;
      released_q <= released_d;
      held_q     <= held_d;
    end
  end

  always_comb begin
    result_o.sda_drive_enable = !released_d;
    result_o.sda_drive_value  = !released_d && drive_d;
    result_o.start_seen       = flags_d_i.start;
    result_o.received_byte    = held_d;
    result_o.received_valid   = rx_valid;
  end

endmodule

// File: hw/rtl/i2c_target_byte_engine_unit.sv
// I2C target byte engine, fed with one oversampled bus sample per transfer.
// in_i carries restart, the sampled scl/sda levels and the reply byte for reads;
// out_o returns one result per sample: sda drive enable and level, the start
// pulse, and the received byte with its valid flag at each acknowledge clock.
// Each accepted sample updates the start/stop watchers and the byte engine in
// the same cycle; the result lands in an output register and is offered in the
// cycle after acceptance. Throughput is one sample per cycle while the output
// register is empty or the receiver takes the held result.
// A stalled receiver holds the result register; a new sample is still taken
// in the cycle the held result is transferred, so no bubble appears.
// Watcher flags act on the engine one sample after they are raised.
// Reset (rst_ni low) puts all protocol state at idle with the line released
// and empties the output register. A sample with restart set does the same
// to the protocol state and returns a released, all-zero result.
module i2c_target_byte_engine_unit (
  input  logic  clk_i,
  input  logic  rst_ni,
  i2cte_in_if.sink    in_i,
  i2cte_out_if.source out_o
);

  logic               advance;
  logic               out_valid_q;
  i2cte_pkg::flags_t  flags_q, flags_d;
  i2cte_pkg::result_t result_d, result_q;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign advance    = in_i.valid && in_i.ready;

  i2cte_cond_watch u_watch (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .restart_i (in_i.restart),
    .scl_i     (in_i.scl_level),
    .sda_i     (in_i.sda_level),
    .flags_q_o (flags_q),
    .flags_d_o (flags_d)
  );

  i2cte_byte_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .restart_i    (in_i.restart),
    .scl_i        (in_i.scl_level),
    .sda_i        (in_i.sda_level),
    .reply_byte_i (in_i.reply_byte),
    .flags_q_i    (flags_q),
    .flags_d_i    (flags_d),
    .result_o     (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) result_q <= result_d;
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.sda_drive_enable = result_q.sda_drive_enable;
  assign out_o.sda_drive_value  = result_q.sda_drive_value;
  assign out_o.start_seen       = result_q.start_seen;
  assign out_o.received_byte    = result_q.received_byte;
  assign out_o.received_valid   = result_q.received_valid;

endmodule

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LAST_DATA_BIT = 7;
  localparam int unsigned ACK_SLOT = 8;
  localparam int PHASE_SAMPLES = 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [1:0] {ENG_IDLE, ENG_ARM, ENG_WAIT_HIGH, ENG_WAIT_LOW} engine_phase_e;
  typedef enum logic [1:0] {XFER_ADDRESS, XFER_WRITE, XFER_READ} xfer_kind_e;
  typedef enum logic [1:0] {SW_WAIT_HIGH, SW_SAW_LOW, SW_SAW_HIGH} start_watch_e;

  typedef struct packed {
    logic       restart;
    logic       scl;
    logic       sda;
    logic [7:0] reply;
  } bus_sample_t;

  class bus_result_checker;
    engine_phase_e        eng_phase;
    xfer_kind_e           kind;
    logic [7:0]           shift_byte;
    logic [3:0]           bit_pos;
    logic                 controller_ack;
    logic [7:0]           reply_latch;
    logic                 drive_level;
    logic                 line_released;
    start_watch_e         start_watch;
    logic                 stop_armed;
    logic                 start_flag;
    logic                 stop_flag;
    logic [7:0]           held_byte;
    i2cte_pkg::result_t   expected_q[$];
    int                   mismatches;
    int                   checked;

    function new();
      clear();
      mismatches = 0;
      checked = 0;
    endfunction

    function void clear();
      eng_phase = ENG_IDLE;
      kind = XFER_ADDRESS;
      shift_byte = '0;
      bit_pos = '0;
      controller_ack = 1'b1;
      reply_latch = '0;
      drive_level = 1'b1;
      line_released = 1'b1;
      start_watch = SW_WAIT_HIGH;
      stop_armed = 1'b0;
      start_flag = 1'b0;
      stop_flag = 1'b0;
      held_byte = '0;
    endfunction

    // level the target puts on the wired-and data line
    function logic line_level();
      return line_released ? 1'b1 : drive_level;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function i2cte_pkg::result_t predict(bus_sample_t s);
      i2cte_pkg::result_t r;
      logic               byte_done;
      r = '0;
      byte_done = 1'b0;
      if (s.restart) begin
        clear();
        return r;
      end
      // engine acts on the watcher flags of the previous sample
      if (stop_flag) begin
        eng_phase = ENG_IDLE;
        line_released = 1'b1;
      end else begin
        case (eng_phase)
          ENG_IDLE: begin
            line_released = 1'b1;
            if (start_flag) begin
              reply_latch = s.reply;
              eng_phase = ENG_ARM;
              kind = XFER_ADDRESS;
              controller_ack = 1'b1;
            end
          end
          ENG_ARM: begin
            if (!s.scl) begin
              eng_phase = ENG_WAIT_HIGH;
              bit_pos = '0;
              shift_byte = '0;
            end
          end
          ENG_WAIT_HIGH: begin
            if (s.scl) begin
              eng_phase = ENG_WAIT_LOW;
              if (kind != XFER_READ && bit_pos < ACK_SLOT)
                shift_byte[LAST_DATA_BIT - bit_pos] = s.sda;
              if (kind == XFER_READ && bit_pos == ACK_SLOT)
                controller_ack = s.sda;
              if (bit_pos == ACK_SLOT) begin
                bit_pos = '0;
                held_byte = shift_byte;
                byte_done = 1'b1;
              end else begin
                bit_pos = bit_pos + 4'd1;
              end
            end
          end
          default: begin
            if (start_flag) begin
              eng_phase = ENG_ARM;
              kind = XFER_ADDRESS;
              controller_ack = 1'b1;
            end else if (!s.scl) begin
              eng_phase = ENG_WAIT_HIGH;
              if (bit_pos == ACK_SLOT) begin
                if (kind == XFER_READ) begin
                  line_released = 1'b1;
                end else begin
                  line_released = 1'b0;
                  drive_level = 1'b0;
                end
                if (kind == XFER_ADDRESS)
                  kind = shift_byte[0] ? XFER_READ : XFER_WRITE;
              end else if (kind == XFER_READ) begin
                line_released = controller_ack;
                if (bit_pos <= LAST_DATA_BIT)
                  drive_level = reply_latch[LAST_DATA_BIT - bit_pos];
              end else begin
                line_released = 1'b1;
              end
            end
          end
        endcase
      end

      // start: sda falls while scl is high
      start_flag = 1'b0;
      case (start_watch)
        SW_WAIT_HIGH: begin
          if (s.scl) start_watch = s.sda ? SW_SAW_HIGH : SW_SAW_LOW;
        end
        SW_SAW_LOW: begin
          if (!s.scl) start_watch = SW_WAIT_HIGH;
          else if (s.sda) start_watch = SW_SAW_HIGH;
        end
        SW_SAW_HIGH: begin
          if (!s.scl) begin
            start_watch = SW_WAIT_HIGH;
          end else if (!s.sda) begin
            start_flag = 1'b1;
            start_watch = SW_WAIT_HIGH;
          end
        end
        default: start_watch = SW_WAIT_HIGH;
      endcase

      // stop: sda rises while scl is high
      stop_flag = 1'b0;
      if (!stop_armed) begin
        if (s.scl && !s.sda) stop_armed = 1'b1;
      end else if (s.scl && s.sda) begin
        stop_flag = 1'b1;
        stop_armed = 1'b0;
      end else if (!s.scl) begin
        stop_armed = 1'b0;
      end

      r.sda_drive_enable = !line_released;
      r.sda_drive_value = line_released ? 1'b0 : drive_level;
      r.start_seen = start_flag;
      r.received_byte = held_byte;
      r.received_valid = byte_done;
      return r;
    endfunction

    function void note_sample(bus_sample_t s);
      expected_q.push_back(predict(s));
    endfunction

    function void check_result(i2cte_pkg::result_t got);
      i2cte_pkg::result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing expected: en=%b val=%b start=%b byte=%02h rv=%b",
                   checked, got.sda_drive_enable, got.sda_drive_value, got.start_seen,
                   got.received_byte, got.received_valid);
        return;
      end
      want = expected_q.pop_front();
      if (got.sda_drive_enable !== want.sda_drive_enable ||
          got.sda_drive_value !== want.sda_drive_value ||
          got.start_seen !== want.start_seen ||
          got.received_byte !== want.received_byte ||
          got.received_valid !== want.received_valid) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"bad result %0d: expected en=%b val=%b start=%b byte=%02h rv=%b,",
                    " got en=%b val=%b start=%b byte=%02h rv=%b"},
                   checked, want.sda_drive_enable, want.sda_drive_value, want.start_seen,
                   want.received_byte, want.received_valid, got.sda_drive_enable,
                   got.sda_drive_value, got.start_seen, got.received_byte,
                   got.received_valid);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  int   samples_sent = 0;
  int   cycle_count = 0;

  bus_result_checker results = new();

  i2cte_in_if  in_if ();
  i2cte_out_if out_if ();

  i2c_target_byte_engine_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      results.check_result({out_if.sda_drive_enable, out_if.sda_drive_value,
                            out_if.start_seen, out_if.received_byte,
                            out_if.received_valid});
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("i2c_target_byte_engine_unit: mismatch");
      $finish;
    end
  end

  // one bus sample per transfer; called and returning at a falling edge
  task automatic put_sample(input logic rst_bit, input logic scl, input logic sda,
                            input logic [7:0] reply);
    bus_sample_t s;
    s.restart = rst_bit;
    s.scl = scl;
    s.sda = sda;
    s.reply = reply;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.restart <= rst_bit;
    in_if.scl_level <= scl;
    in_if.sda_level <= sda;
    in_if.reply_byte <= reply;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    results.note_sample(s);
    samples_sent++;
    @(negedge clk_i);
  endtask

  // controller level wired-and with whatever the target drives
  task automatic hold_lines(input logic scl, input logic sda, input int n);
    repeat (n) put_sample(1'b0, scl, sda & results.line_level(), 8'($urandom));
  endtask

  task automatic bus_bit(input logic b);
    hold_lines(1'b0, b, $urandom_range(1, 3));
    hold_lines(1'b1, b, $urandom_range(1, 3));
  endtask

  task automatic bus_start();
    hold_lines(1'b0, 1'b1, $urandom_range(1, 2));
    hold_lines(1'b1, 1'b1, $urandom_range(1, 3));
    hold_lines(1'b1, 1'b0, $urandom_range(2, 3));
  endtask

  task automatic bus_stop();
    hold_lines(1'b0, 1'b0, $urandom_range(1, 3));
    hold_lines(1'b1, 1'b0, $urandom_range(1, 3));
    hold_lines(1'b1, 1'b1, $urandom_range(1, 4));
  endtask

  task automatic bus_byte(input logic [7:0] data, input logic ack_bit);
    for (int i = 7; i >= 0; i--) bus_bit(data[i]);
    bus_bit(ack_bit);
  endtask

  // start, address, a few bytes, maybe a repeated start, then stop
  task automatic bus_session();
    int         n_xfers;
    int         n_bytes;
    logic [7:0] addr;
    logic       aborted;
    logic       last;
    n_xfers = $urandom_range(1, 2);
    aborted = 1'b0;
    for (int x = 0; x < n_xfers && !aborted; x++) begin
      bus_start();
      addr = 8'($urandom);
      bus_byte(addr, 1'b1);
      n_bytes = $urandom_range(0, 3);
      for (int b = 0; b < n_bytes && !aborted; b++) begin
        last = (b == n_bytes - 1);
        if ($urandom_range(19) == 0) begin
          // broken transfer: bus stops in the middle of a byte
          repeat ($urandom_range(1, 7)) bus_bit(1'($urandom));
          aborted = 1'b1;
        end else if (addr[0]) begin
          bus_byte(8'hFF, last ? ($urandom_range(7) != 0) : ($urandom_range(9) == 0));
        end else begin
          bus_byte(8'($urandom), 1'b1);
        end
      end
    end
    bus_stop();
  endtask

  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (results.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic directed_samples();
    put_sample(1'b1, 1'b1, 1'b1, 8'hFF);
    put_sample(1'b0, 1'b1, 1'b1, 8'h00);
    put_sample(1'b0, 1'b1, 1'b0, 8'h00);  // start flagged
    put_sample(1'b0, 1'b1, 1'b0, 8'hFF);  // idle engine latches reply
    put_sample(1'b0, 1'b0, 1'b1, 8'h00);
    put_sample(1'b0, 1'b1, 1'b1, 8'h00);
    put_sample(1'b0, 1'b0, 1'b1, 8'hFF);
    put_sample(1'b0, 1'b1, 1'b1, 8'h00);
    put_sample(1'b0, 1'b1, 1'b0, 8'h00);  // repeated start while waiting for scl low
    put_sample(1'b0, 1'b1, 1'b0, 8'h00);
    put_sample(1'b0, 1'b0, 1'b0, 8'hFF);
    put_sample(1'b0, 1'b1, 1'b0, 8'h00);
    put_sample(1'b0, 1'b1, 1'b1, 8'hFF);  // stop flagged
    put_sample(1'b0, 1'b1, 1'b1, 8'h00);
    put_sample(1'b0, 1'b1, 1'b0, 8'hA5);
    put_sample(1'b0, 1'b1, 1'b0, 8'h5A);
    put_sample(1'b0, 1'b0, 1'b0, 8'h00);
    put_sample(1'b1, 1'b0, 1'b0, 8'h00);  // restart in the middle of a transfer
    put_sample(1'b0, 1'b0, 1'b0, 8'hFF);
    put_sample(1'b0, 1'b1, 1'b1, 8'h00);
    put_sample(1'b1, 1'b0, 1'b1, 8'hFF);
  endtask

  task automatic random_traffic(input int n_samples);
    int stop_at;
    int pick;
    stop_at = samples_sent + n_samples;
    while (samples_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        bus_session();
      end else if (pick < 93) begin
        repeat ($urandom_range(3, 16))
          put_sample(1'b0, 1'($urandom), 1'($urandom), 8'($urandom));
      end else begin
        put_sample(1'b1, 1'($urandom), 1'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.restart = 1'b0;
    in_if.scl_level = 1'b1;
    in_if.sda_level = 1'b1;
    in_if.reply_byte = 8'h00;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_samples();
    random_traffic(PHASE_SAMPLES);
    wait_for_results();

    sender_idle_pct = 62;
    receiver_stall_pct = 0;
    random_traffic(PHASE_SAMPLES);
    wait_for_results();

    sender_idle_pct = 0;
    receiver_stall_pct = 62;
    random_traffic(PHASE_SAMPLES);
    wait_for_results();

    sender_idle_pct = 37;
    receiver_stall_pct = 37;
    random_traffic(PHASE_SAMPLES);
    wait_for_results();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (results.mismatches == 0 && results.pending() == 0) begin
      $display("i2c_target_byte_engine_unit: match");
    end else begin
      $display("i2c_target_byte_engine_unit: mismatch");
    end
    $finish;
  end

endmodule

// File: i2c_target_byte_engine_unit.f
hw/rtl/i2cte_pkg.sv
hw/rtl/i2cte_in_if.sv
hw/rtl/i2cte_out_if.sv
hw/rtl/i2cte_cond_watch.sv
hw/rtl/i2cte_byte_engine.sv
hw/rtl/i2c_target_byte_engine_unit.sv
sim/tb_top.sv
